// File: hw/rtl/tsce_pkg.sv
// ----------------------------------------------------------------------------
// tsce_pkg
// shared types, command codes and swap arc tables of the tour swap evaluator
// ----------------------------------------------------------------------------
package tsce_pkg;

	// command codes carried in s_tuser
	localparam logic [2:0] CMD_LOAD_ARC  = 3'd0;
	localparam logic [2:0] CMD_LOAD_TOUR = 3'd1;
	localparam logic [2:0] CMD_EVAL      = 3'd2;
	localparam logic [2:0] CMD_APPLY     = 3'd3;
	localparam logic [2:0] CMD_WALK      = 3'd4;

	// register byte addresses
	localparam logic [2:0] REG_NODE_COUNT = 3'd0;

	// result field widths
	localparam int LEN_DELTA_W  = 19;
	localparam int MISS_DELTA_W = 4;
	localparam int TOUR_LEN_W   = 22;
	localparam int MISS_CNT_W   = 7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_TOUR,
		ST_ARC,
		ST_WALK,
		ST_SWAP_A,
		ST_SWAP_B,
		ST_DONE
	} tsce_state_t;

	// which arcs a swap replaces
	typedef enum logic [1:0] {
		MODE_GEN  = 2'd0,
		MODE_ADJ  = 2'd1,
		MODE_WRAP = 2'd2
	} swap_mode_t;

	// fetched neighborhood slots: 0 node(a) 1 node(d) 2 node(a-1) 3 node(a+1)
	// 4 node(d-1) 5 node(d+1)
	typedef logic [2:0] slot_sel_t;

	localparam slot_sel_t ARC_SRC [4][8] = '{
		'{3'd2, 3'd0, 3'd4, 3'd1, 3'd2, 3'd1, 3'd4, 3'd0},
		'{3'd2, 3'd0, 3'd1, 3'd2, 3'd1, 3'd0, 3'd0, 3'd0},
		'{3'd4, 3'd1, 3'd0, 3'd4, 3'd0, 3'd1, 3'd0, 3'd0},
		'{3'd2, 3'd0, 3'd4, 3'd1, 3'd2, 3'd1, 3'd4, 3'd0}
	};
	localparam slot_sel_t ARC_DST [4][8] = '{
		'{3'd0, 3'd3, 3'd1, 3'd5, 3'd1, 3'd3, 3'd0, 3'd5},
		'{3'd0, 3'd1, 3'd5, 3'd1, 3'd0, 3'd5, 3'd0, 3'd0},
		'{3'd1, 3'd0, 3'd3, 3'd0, 3'd1, 3'd3, 3'd0, 3'd0},
		'{3'd0, 3'd3, 3'd1, 3'd5, 3'd1, 3'd3, 3'd0, 3'd5}
	};
	// 1 adds the arc (new tour), 0 removes it (old tour)
	localparam logic [7:0] ARC_ADD [4] = '{
		8'b1111_0000,
		8'b0011_1000,
		8'b0011_1000,
		8'b1111_0000
	};

	function automatic logic [6:0] pos_prev(input logic [6:0] x, input logic [6:0] n);
		pos_prev = (x == 7'd0) ? n - 7'd1 : x - 7'd1;
	endfunction

	function automatic logic [6:0] pos_next(input logic [6:0] x, input logic [6:0] n);
		pos_next = (x + 7'd1 == n) ? 7'd0 : x + 7'd1;
	endfunction

endpackage

// File: hw/rtl/tsce_ram.sv
// ----------------------------------------------------------------------------
// tsce_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module tsce_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/tour_swap_cost_evaluator_top.sv
// ----------------------------------------------------------------------------
// tour_swap_cost_evaluator_top
// arc cost matrix and cyclic tour held in rams, swap move and tour walk engine
// ----------------------------------------------------------------------------
// usage
//   s_* stream takes one command beat: s_tuser holds the command, s_tdata the
//   arc, tour entry and swap operands. every command gives exactly one m_*
//   result beat (deltas, walk totals and the status flag in m_tuser).
//   node_count is written over the apb port, by the user only while the block is idle; the block does not enforce this.
// sequencing
//   arc and tour loads: the ram is written in the exec state, and the result is sent from the done state.
//   evaluate: 6 tour ram reads, then 8 arc ram reads for a general swap or 6 for
//   adjacent and wrap-adjacent swaps, one read a cycle on the single arc ram
//   read port; apply then writes the exchanged tour entries back in the
//   swap_a and swap_b states.
//   walk: one tour read and one arc read per node, overlapped.
//   one command is worked on at a time; a new beat is taken once the engine
//   is back in idle, even while the previous result still waits on m_tready.
// reset
//   arst_n clears control state and sets node_count to 64. the ram contents
//   are undefined until loaded; there is no clearing pass.
// stall
//   a result waits in the output register; if a second result is ready before
//   it drains, the engine holds in its done state and takes no new beat.
// ----------------------------------------------------------------------------
module tour_swap_cost_evaluator_top
	import tsce_pkg::*;
#(
	parameter int MAX_NODES = 64,
	parameter int COST_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// command stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// from_node[5:0] to_node[11:6] arc_value[27:12] tour_slot[33:28]
	// tour_node[39:34] swap_first[45:40] swap_second[51:46] zero[55:52]
	input  logic [55:0] s_tdata,
	// cmd[2:0]
	input  logic [2:0]  s_tuser,
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// length_delta[18:0] missing_delta[22:19] tour_length[44:23]
	// missing_count[51:45] zero[55:52]
	output logic [55:0] m_tdata,
	// status[0]
	output logic [0:0]  m_tuser,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int NW = $clog2(MAX_NODES);

	// configuration
	logic [6:0] node_count_q;
	logic [6:0] n;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_NODE_COUNT) ? {25'd0, node_count_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= 7'd64;
		end else if (psel && penable && pwrite && pready && paddr == REG_NODE_COUNT) begin
			node_count_q <= pwdata[6:0];
		end
	end

	// effective tour size, saturated into [3, MAX_NODES]
	always_comb begin
		if (node_count_q < 7'd3) begin
			n = 7'd3;
		end else if (int'(node_count_q) > MAX_NODES) begin
			n = 7'(MAX_NODES);
		end else begin
			n = node_count_q;
		end
	end

	// command register
	logic [2:0]  cmd_q;
	logic [5:0]  from_q, to_q, slot_q, tnode_q, p1_q, p2_q;
	logic [15:0] val_q;

	tsce_state_t state_q, state_d;

	// swap working registers
	logic [6:0]      a_q, d_q;
	swap_mode_t      mode_q;
	logic [NW-1:0]   node_q [6];
	logic [6:0]      t_idx_q;
	logic            t_vld_q;
	logic            a_vld_q;
	logic            sign_q;
	logic [3:0]      k_q;
	logic [3:0]      arc_cnt;
	logic            closed_q;
	logic [6:0]      acc_cnt_q;
	logic [NW-1:0]   first_q, prev_q;
	logic [TOUR_LEN_W-1:0]   len_q;
	logic [MISS_CNT_W-1:0]   miss_q;
	logic [LEN_DELTA_W-1:0]  dlen_q;
	logic [MISS_DELTA_W-1:0] dmiss_q;
	logic                    status_q;

	// ram ports
	logic              tour_we;
	logic [NW-1:0]     tour_waddr, tour_wdata, tour_raddr, tour_rdata;
	logic              arc_we, arc_re;
	logic [2*NW-1:0]   arc_waddr, arc_raddr;
	logic [COST_BITS-1:0] arc_wdata, arc_rdata;
	logic              arc_add;

	tsce_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_tour_ram (
		.clk  (clk),
		.we   (tour_we),
		.waddr(tour_waddr),
		.wdata(tour_wdata),
		.raddr(tour_raddr),
		.rdata(tour_rdata)
	);

	tsce_ram #(.WIDTH(COST_BITS), .DEPTH(1 << (2 * NW))) u_arc_ram (
		.clk  (clk),
		.we   (arc_we),
		.waddr(arc_waddr),
		.wdata(arc_wdata),
		.raddr(arc_raddr),
		.rdata(arc_rdata)
	);

	// swap neighborhood positions
	logic [6:0] pos [6];
	always_comb begin
		pos[0] = a_q;
		pos[1] = d_q;
		pos[2] = pos_prev(a_q, n);
		pos[3] = pos_next(a_q, n);
		pos[4] = pos_prev(d_q, n);
		pos[5] = pos_next(d_q, n);
	end

	assign arc_cnt = (mode_q == MODE_GEN) ? 4'd8 : 4'd6;

	// decode of the command held in the input register
	logic [5:0] lo_pos, hi_pos;
	logic       bad_swap;
	swap_mode_t mode_d;
	always_comb begin
		lo_pos   = (p1_q < p2_q) ? p1_q : p2_q;
		hi_pos   = (p1_q < p2_q) ? p2_q : p1_q;
		bad_swap = (p1_q == p2_q) || ({1'b0, p1_q} >= n) || ({1'b0, p2_q} >= n);
		if (hi_pos == lo_pos + 6'd1) begin
			mode_d = MODE_ADJ;
		end else if (lo_pos == 6'd0 && {1'b0, hi_pos} == n - 7'd1) begin
			mode_d = MODE_WRAP;
		end else begin
			mode_d = MODE_GEN;
		end
	end

	// walk: close the ring after the last tour entry is in
	logic walk_close;
	assign walk_close = !t_vld_q && t_idx_q == n && !closed_q;

	logic out_free;
	assign out_free = !m_tvalid || m_tready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if ((cmd_q == CMD_EVAL || cmd_q == CMD_APPLY) && !bad_swap) begin
					state_d = ST_TOUR;
				end else if (cmd_q == CMD_WALK) begin
					state_d = ST_WALK;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_TOUR: begin
				if (t_vld_q && t_idx_q == 7'd6) state_d = ST_ARC;
			end
			ST_ARC: begin
				if (a_vld_q && k_q == arc_cnt) begin
					state_d = (cmd_q == CMD_APPLY) ? ST_SWAP_A : ST_DONE;
				end
			end
			ST_WALK: begin
				if (a_vld_q && acc_cnt_q == n - 7'd1) state_d = ST_DONE;
			end
			ST_SWAP_A: state_d = ST_SWAP_B;
			ST_SWAP_B: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ram control and handshake outputs
	always_comb begin
		s_tready   = 1'b0;
		tour_we    = 1'b0;
		tour_waddr = NW'(slot_q);
		tour_wdata = NW'(tnode_q);
		tour_raddr = NW'(t_idx_q);
		arc_we     = 1'b0;
		arc_waddr  = {NW'(from_q), NW'(to_q)};
		arc_wdata  = COST_BITS'(val_q);
		arc_re     = 1'b0;
		arc_raddr  = {prev_q, tour_rdata};
		arc_add    = 1'b0;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_EXEC: begin
				arc_we  = cmd_q == CMD_LOAD_ARC && int'(from_q) < MAX_NODES
					&& int'(to_q) < MAX_NODES;
				tour_we = cmd_q == CMD_LOAD_TOUR && int'(slot_q) < MAX_NODES
					&& int'(tnode_q) < MAX_NODES;
			end
			ST_TOUR: begin
				tour_raddr = (t_idx_q < 7'd6) ? NW'(pos[t_idx_q[2:0]]) : NW'(a_q);
			end
			ST_ARC: begin
				arc_re    = k_q < arc_cnt;
				arc_raddr = {node_q[ARC_SRC[mode_q][k_q[2:0]]],
					node_q[ARC_DST[mode_q][k_q[2:0]]]};
				arc_add   = ARC_ADD[mode_q][k_q[2:0]];
			end
			ST_WALK: begin
				if (t_vld_q && t_idx_q != 7'd1) begin
					arc_re = 1'b1;
				end else if (walk_close) begin
					arc_re    = 1'b1;
					arc_raddr = {prev_q, first_q};
				end
			end
			ST_SWAP_A: begin
				tour_we    = 1'b1;
				tour_waddr = NW'(a_q);
				tour_wdata = node_q[1];
			end
			ST_SWAP_B: begin
				tour_we    = 1'b1;
				tour_waddr = NW'(d_q);
				tour_wdata = node_q[0];
			end
			ST_DONE: ;
			default: ;
		endcase
	end

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			t_idx_q   <= 7'd0;
			t_vld_q   <= 1'b0;
			a_vld_q   <= 1'b0;
			k_q       <= 4'd0;
			closed_q  <= 1'b0;
			acc_cnt_q <= 7'd0;
			m_tvalid  <= 1'b0;
		end else begin
			state_q <= state_d;
			a_vld_q <= arc_re;
			if (state_q == ST_EXEC) begin
				t_idx_q   <= 7'd0;
				t_vld_q   <= 1'b0;
				k_q       <= 4'd0;
				closed_q  <= 1'b0;
				acc_cnt_q <= 7'd0;
			end
			if (state_q == ST_TOUR) begin
				t_vld_q <= t_idx_q < 7'd6;
				if (t_idx_q < 7'd6) t_idx_q <= t_idx_q + 7'd1;
			end
			if (state_q == ST_WALK) begin
				t_vld_q <= t_idx_q < n;
				if (t_idx_q < n) t_idx_q <= t_idx_q + 7'd1;
				if (walk_close) closed_q <= 1'b1;
				if (a_vld_q) acc_cnt_q <= acc_cnt_q + 7'd1;
			end
			if (state_q == ST_ARC && arc_re) k_q <= k_q + 4'd1;
			if (state_q == ST_DONE && out_free) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q   <= s_tuser;
			from_q  <= s_tdata[5:0];
			to_q    <= s_tdata[11:6];
			val_q   <= s_tdata[27:12];
			slot_q  <= s_tdata[33:28];
			tnode_q <= s_tdata[39:34];
			p1_q    <= s_tdata[45:40];
			p2_q    <= s_tdata[51:46];
		end
		sign_q <= arc_add;
		unique case (state_q)
			ST_EXEC: begin
				a_q      <= {1'b0, lo_pos};
				d_q      <= {1'b0, hi_pos};
				mode_q   <= mode_d;
				len_q    <= '0;
				miss_q   <= '0;
				dlen_q   <= '0;
				dmiss_q  <= '0;
				status_q <= (cmd_q == CMD_EVAL || cmd_q == CMD_APPLY) && bad_swap;
			end
			ST_TOUR: begin
				for (int i = 0; i < 6; i++) begin
					if (t_vld_q && t_idx_q == 7'(i + 1)) node_q[i] <= tour_rdata;
				end
			end
			ST_ARC: begin
				if (a_vld_q) begin
					if (sign_q) begin
						dlen_q <= dlen_q + LEN_DELTA_W'(arc_rdata);
						if (arc_rdata == '0) dmiss_q <= dmiss_q + 4'd1;
					end else begin
						dlen_q <= dlen_q - LEN_DELTA_W'(arc_rdata);
						if (arc_rdata == '0) dmiss_q <= dmiss_q - 4'd1;
					end
				end
			end
			ST_WALK: begin
				if (t_vld_q) begin
					prev_q <= tour_rdata;
					if (t_idx_q == 7'd1) first_q <= tour_rdata;
				end
				if (a_vld_q) begin
					len_q <= len_q + TOUR_LEN_W'(arc_rdata);
					if (arc_rdata == '0) miss_q <= miss_q + 7'd1;
				end
			end
			default: ;
		endcase
		if (state_q == ST_DONE && out_free) begin
			if (cmd_q == CMD_EVAL || cmd_q == CMD_APPLY) begin
				m_tdata <= {4'd0, 7'd0, 22'd0, dmiss_q, dlen_q};
			end else if (cmd_q == CMD_WALK) begin
				m_tdata <= {4'd0, miss_q, len_q, 4'd0, 19'd0};
			end else begin
				m_tdata <= '0;
			end
			m_tuser <= status_q;
		end
	end

	// checks
	ap_no_tour_write_while_reading: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TOUR || state_q == ST_WALK || state_q == ST_ARC) |-> !tour_we)
		else $error("tour ram written during a read phase");

	ap_bad_swap_zero_delta: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && status_q) |-> (dlen_q == '0 && dmiss_q == '0))
		else $error("flagged swap carries a nonzero delta");

	ap_walk_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> acc_cnt_q < n)
		else $error("walk summed more arcs than tour nodes");

	ap_arc_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ARC |-> k_q <= arc_cnt)
		else $error("swap issued more arc reads than its rule has");

endmodule
